// ----- rtl/core/ffha_pkg.sv -----
package ffha_pkg;

  localparam int unsigned MaxBlocksDef = 64;
  localparam int unsigned HeaderBytesDef = 20;
  localparam int unsigned MinSplitSlackDef = 16;

  localparam logic [31:0] SizeLimit = 32'hFFFF_FFF0;

  // commands
  localparam logic [1:0] CmdInit = 2'd0;
  localparam logic [1:0] CmdAlloc = 2'd1;
  localparam logic [1:0] CmdFree = 2'd2;
  localparam logic [1:0] CmdStats = 2'd3;

  // result status codes
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFail = 2'd1;
  localparam logic [1:0] StBadFree = 2'd2;

  // configuration register indexes
  localparam logic CfgHeapBase = 1'b0;
  localparam logic CfgHeapBytes = 1'b1;

  // per-cell contents
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        free;
  } cell_t;

  // operation broadcast by the controller to every cell
  localparam logic [2:0] OpNone = 3'd0;
  localparam logic [2:0] OpInit = 3'd1;
  localparam logic [2:0] OpInsert = 3'd2;
  localparam logic [2:0] OpRemove = 3'd3;
  localparam logic [2:0] OpWrite = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    cell_t       wdata;
    logic [31:0] sz;
    logic [31:0] addr;
  } ctl_t;

endpackage

// ----- rtl/core/ffha_cell.sv -----
// one table entry; shifts with its neighbours on insert or remove
module ffha_cell #(
  parameter int unsigned IdxW = 6,
  parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDef
) (
  input  logic                  clk,
  input  logic [IdxW-1:0]       my_idx,
  input  logic [IdxW-1:0]       sel_idx,
  input  ffha_pkg::ctl_t        ctl,
  input  ffha_pkg::cell_t       left_i,
  input  ffha_pkg::cell_t       right_i,
  output ffha_pkg::cell_t       cell_o,
  output logic                  fit_o,
  output logic                  hit_o
);

  ffha_pkg::cell_t cell_r;
  ffha_pkg::cell_t cell_nxt;

  // next contents by broadcast operation
  always_comb begin
    cell_nxt = cell_r;
    unique case (ctl.op)
      ffha_pkg::OpInit: begin
        if (my_idx == '0) cell_nxt = ctl.wdata;
      end
      ffha_pkg::OpInsert: begin
        if (my_idx > sel_idx) cell_nxt = left_i;
      end
      ffha_pkg::OpRemove: begin
        if (my_idx >= sel_idx) cell_nxt = right_i;
      end
      ffha_pkg::OpWrite: begin
        if (my_idx == sel_idx) cell_nxt = ctl.wdata;
      end
      default: cell_nxt = cell_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  // local match flags for the search
  assign fit_o = cell_r.free && (cell_r.size >= ctl.sz);
  assign hit_o = !cell_r.free &&
                 ((cell_r.offset + 32'(HeaderBytes)) == ctl.addr);
  assign cell_o = cell_r;

endmodule

// ----- rtl/core/ffha_chain.sv -----
// row of cells with neighbour links and per-entry match flags
module ffha_chain #(
  parameter int unsigned MaxBlocks = ffha_pkg::MaxBlocksDef,
  parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDef,
  parameter int unsigned IdxW = $clog2(MaxBlocks)
) (
  input  logic                  clk,
  input  ffha_pkg::ctl_t        ctl,
  input  logic [IdxW-1:0]       sel_idx,
  input  logic [IdxW:0]         live,
  input  logic [IdxW-1:0]       rd_idx,
  output ffha_pkg::cell_t       rd_cell,
  output logic [MaxBlocks-1:0]  fit_vec,
  output logic [MaxBlocks-1:0]  hit_vec
);

  ffha_pkg::cell_t cells [MaxBlocks];
  logic [MaxBlocks-1:0] fit_raw;
  logic [MaxBlocks-1:0] hit_raw;

  for (genvar g = 0; g < MaxBlocks; g++) begin : g_cell
    ffha_pkg::cell_t lft;
    ffha_pkg::cell_t rgt;
    if (g == 0) begin : g_first
      assign lft = cells[g];
    end else begin : g_mid
      assign lft = cells[g-1];
    end
    if (g == MaxBlocks - 1) begin : g_last
      assign rgt = cells[g];
    end else begin : g_inner
      assign rgt = cells[g+1];
    end
    ffha_cell #(.IdxW(IdxW), .HeaderBytes(HeaderBytes)) u_cell (
      .clk    (clk),
      .my_idx (IdxW'(g)),
      .sel_idx(sel_idx),
      .ctl    (ctl),
      .left_i (lft),
      .right_i(rgt),
      .cell_o (cells[g]),
      .fit_o  (fit_raw[g]),
      .hit_o  (hit_raw[g])
    );
    // only live entries take part in the search
    assign fit_vec[g] = fit_raw[g] && ((IdxW+1)'(g) < live);
    assign hit_vec[g] = hit_raw[g] && ((IdxW+1)'(g) < live);
  end

  assign rd_cell = cells[rd_idx];

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator. The block table lives in a row of cells that
// shift together when a block is split or merged. Commands are issued with
// start while busy is low; each command gives exactly one result, shown for
// one cycle with out_valid, which the receiver must take at once. Init,
// statistics, a free of address zero and an allocate rejected up front go
// straight to the result; an allocate or free that finds no block fails
// after the search. An allocate writes the block it finds, splitting it when
// the slack allows, and a free marks its block free, then merges it with a
// free following block and then with a free predecessor. The table
// controller issues one table operation per cycle. busy stays high through
// the result cycle, so the next command is taken in the cycle after it at
// the earliest.
module first_fit_heap_allocator #(
  parameter int unsigned MaxBlocks = ffha_pkg::MaxBlocksDef,
  parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytesDef,
  parameter int unsigned MinSplitSlack = ffha_pkg::MinSplitSlackDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_request_bytes,
  input  logic [31:0] in_data_address,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [31:0] out_total_bytes,
  output logic [31:0] out_used_bytes,
  output logic [6:0]  out_block_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam logic [IdxW:0] MaxLive = (IdxW+1)'(MaxBlocks);
  localparam logic [IdxW-1:0] IdxOne = IdxW'(1);
  localparam logic [IdxW:0] LiveOne = (IdxW+1)'(1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_ALOC = 4'd2;
  localparam logic [3:0] S_SPLT = 4'd3;
  localparam logic [3:0] S_FRD = 4'd4;
  localparam logic [3:0] S_MRGC = 4'd5;
  localparam logic [3:0] S_MRGW = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_PRED = 4'd8;
  localparam logic [3:0] S_GROW = 4'd9;

  logic [3:0]      state_r, state_nxt;
  logic [31:0]     base_r, bytes_r;
  logic [IdxW:0]   live_r, live_nxt;
  logic [31:0]     total_r, total_nxt;
  logic [31:0]     used_r, used_nxt;
  logic [31:0]     sz_r, sz_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [1:0]      st_r, st_nxt;
  logic [31:0]     res_addr_r, res_addr_nxt;
  logic            pred_done_r, pred_done_nxt;
  logic            vld_r, vld_nxt;

  ffha_pkg::ctl_t  ctl;
  logic [IdxW-1:0] sel_idx, rd_idx;
  ffha_pkg::cell_t rd_cell, rd_next;
  logic [MaxBlocks-1:0] fit_vec, hit_vec;
  logic            any_fit, any_hit;
  logic [IdxW-1:0] fit_idx, hit_idx;
  logic [31:0]     sz_round;
  logic [33:0]     need;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      bytes_r <= 32'd1048576;
    end else if (cfg_we) begin
      if (cfg_index == ffha_pkg::CfgHeapBase) base_r <= cfg_data;
      else bytes_r <= cfg_data;
    end
  end

  ffha_chain #(.MaxBlocks(MaxBlocks), .HeaderBytes(HeaderBytes), .IdxW(IdxW)) u_chain (
    .clk    (clk),
    .ctl    (ctl),
    .sel_idx(sel_idx),
    .live   (live_r),
    .rd_idx (rd_idx),
    .rd_cell(rd_cell),
    .fit_vec(fit_vec),
    .hit_vec(hit_vec)
  );

  // lowest matching entry
  always_comb begin
    any_fit = 1'b0;
    fit_idx = '0;
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = MaxBlocks - 1; i >= 0; i--) begin
      if (fit_vec[i]) begin
        any_fit = 1'b1;
        fit_idx = IdxW'(i);
      end
      if (hit_vec[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  assign sz_round = (in_request_bytes + 32'd7) & ~32'd7;
  assign need = {2'b00, sz_r} + 34'(HeaderBytes) + 34'(MinSplitSlack);

  // controller
  always_comb begin
    state_nxt = state_r;
    live_nxt = live_r;
    total_nxt = total_r;
    used_nxt = used_r;
    sz_nxt = sz_r;
    addr_nxt = addr_r;
    idx_nxt = idx_r;
    st_nxt = st_r;
    res_addr_nxt = res_addr_r;
    pred_done_nxt = pred_done_r;
    vld_nxt = 1'b0;
    ctl = '0;
    ctl.sz = sz_r;
    ctl.addr = addr_r;
    sel_idx = idx_r;
    rd_idx = idx_r;
    rd_next = rd_cell;
    unique case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          st_nxt = ffha_pkg::StOk;
          res_addr_nxt = '0;
          pred_done_nxt = 1'b0;
          unique case (in_command)
            ffha_pkg::CmdInit: begin
              ctl.op = ffha_pkg::OpInit;
              ctl.wdata.offset = base_r;
              ctl.wdata.size = (bytes_r >= 32'(HeaderBytes)) ?
                               bytes_r - 32'(HeaderBytes) : '0;
              ctl.wdata.free = 1'b1;
              live_nxt = LiveOne;
              total_nxt = bytes_r;
              used_nxt = 32'(HeaderBytes);
              state_nxt = S_DONE;
            end
            ffha_pkg::CmdAlloc: begin
              sz_nxt = sz_round;
              if (in_request_bytes == '0 || in_request_bytes > ffha_pkg::SizeLimit ||
                  sz_round > total_r) begin
                st_nxt = ffha_pkg::StFail;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            ffha_pkg::CmdFree: begin
              addr_nxt = in_data_address;
              state_nxt = (in_data_address == '0) ? S_DONE : S_SRCH;
            end
            ffha_pkg::CmdStats: state_nxt = S_DONE;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH: begin
        // sz_r is zero on a free, so addr_r path decides there
        if (addr_r != '0 && sz_r == '0) begin
          idx_nxt = hit_idx;
          if (any_hit) state_nxt = S_FRD;
          else begin
            st_nxt = ffha_pkg::StBadFree;
            state_nxt = S_DONE;
          end
        end else begin
          idx_nxt = fit_idx;
          if (any_fit) state_nxt = S_ALOC;
          else begin
            st_nxt = ffha_pkg::StFail;
            state_nxt = S_DONE;
          end
        end
      end
      S_ALOC: begin
        // split when slack is large and table has room
        res_addr_nxt = rd_cell.offset + 32'(HeaderBytes);
        if ({2'b00, rd_cell.size} >= need && live_r < MaxLive) begin
          ctl.op = ffha_pkg::OpInsert;
          live_nxt = live_r + LiveOne;
          used_nxt = used_r + 32'(HeaderBytes) + sz_r;
          state_nxt = S_SPLT;
        end else begin
          ctl.op = ffha_pkg::OpWrite;
          ctl.wdata = rd_cell;
          ctl.wdata.free = 1'b0;
          used_nxt = used_r + rd_cell.size;
          state_nxt = S_DONE;
        end
      end
      S_SPLT: begin
        // cell idx+1 still holds the old block copy after the shift
        rd_idx = idx_r + IdxOne;
        ctl.op = ffha_pkg::OpWrite;
        sel_idx = idx_r;
        ctl.wdata.offset = rd_cell.offset;
        ctl.wdata.size = sz_r;
        ctl.wdata.free = 1'b0;
        idx_nxt = idx_r + IdxOne;
        state_nxt = S_MRGW;
        // reuse write state for the tail block
        sz_nxt = rd_cell.size - sz_r - 32'(HeaderBytes);
        addr_nxt = rd_cell.offset + 32'(HeaderBytes) + sz_r;
      end
      S_FRD: begin
        ctl.op = ffha_pkg::OpWrite;
        ctl.wdata = rd_cell;
        ctl.wdata.free = 1'b1;
        used_nxt = used_r - rd_cell.size;
        state_nxt = S_MRGC;
      end
      S_MRGC: begin
        // absorb a free follower into cell idx
        rd_idx = idx_r + IdxOne;
        rd_next = rd_cell;
        if ((IdxW+1)'(idx_r) + LiveOne < live_r && rd_next.free) begin
          sz_nxt = rd_next.size;
          ctl.op = ffha_pkg::OpRemove;
          sel_idx = idx_r + IdxOne;
          live_nxt = live_r - LiveOne;
          used_nxt = used_r - 32'(HeaderBytes);
          state_nxt = S_GROW;
        end else begin
          state_nxt = S_PRED;
        end
      end
      S_PRED: begin
        if (!pred_done_r && idx_r != '0) begin
          rd_idx = idx_r - IdxOne;
          pred_done_nxt = 1'b1;
          if (rd_cell.free) begin
            idx_nxt = idx_r - IdxOne;
            state_nxt = S_MRGC;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MRGW: begin
        ctl.op = ffha_pkg::OpWrite;
        ctl.wdata.offset = addr_r;
        ctl.wdata.size = sz_r;
        ctl.wdata.free = 1'b1;
        sz_nxt = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        vld_nxt = 1'b1;
        sz_nxt = '0;
        addr_nxt = '0;
        state_nxt = S_IDLE;
      end
      S_GROW: begin
        // grow cell idx by the removed follower, then look again
        ctl.op = ffha_pkg::OpWrite;
        ctl.wdata = rd_cell;
        ctl.wdata.size = rd_cell.size + sz_r + 32'(HeaderBytes);
        sz_nxt = '0;
        state_nxt = S_MRGC;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      live_r <= '0;
      total_r <= '0;
      used_r <= '0;
      vld_r <= 1'b0;
      sz_r <= '0;
      addr_r <= '0;
      pred_done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      live_r <= live_nxt;
      total_r <= total_nxt;
      used_r <= used_nxt;
      vld_r <= vld_nxt;
      sz_r <= sz_nxt;
      addr_r <= addr_nxt;
      pred_done_r <= pred_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    st_r <= st_nxt;
    res_addr_r <= res_addr_nxt;
  end

  assign busy = (state_r != S_IDLE) || vld_r;
  assign out_valid = vld_r;
  assign out_status = st_r;
  assign out_block_address = (st_r == ffha_pkg::StOk) ? res_addr_r : '0;
  assign out_total_bytes = total_r;
  assign out_used_bytes = used_r;
  assign out_block_count = 7'(live_r);

`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= MaxLive) else $error("block count above table size");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |=> !vld_r) else $error("result strobe held twice");
  a_done_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> vld_r) else $error("done state gave no result");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ffha_pkg::StOk) |-> out_block_address == '0)
    else $error("address shown on failure");
`endif

endmodule
